[rtl/beep_pattern_sequencer_core_assert.svh]
// Assertion macros shared by the checker.
`ifndef BEEP_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define BPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bps check failed: same-cycle rule");

// Next-cycle implication, masked during reset.
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bps check failed: next-cycle rule");

// Next-cycle implication that also holds across reset.
`define BPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bps check failed: reset rule");

`endif

[rtl/bps_pkg.sv]
package bps_pkg;

   localparam int TICK_W  = 16;
   localparam int COUNT_W = 8;
   localparam int MODE_W  = 2;
   localparam int PHASE_W = 4;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd0;
   localparam logic [PHASE_W-1:0] PH_SHORT_START = 4'd1;
   localparam logic [PHASE_W-1:0] PH_SHORT_ON    = 4'd2;
   localparam logic [PHASE_W-1:0] PH_SHORT_OFF   = 4'd3;
   localparam logic [PHASE_W-1:0] PH_HALF_START  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_HALF_ON     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_HALF_OFF    = 4'd6;
   localparam logic [PHASE_W-1:0] PH_LONG_START  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_LONG_ON     = 4'd8;
   localparam logic [PHASE_W-1:0] PH_LONG_OFF    = 4'd9;
   localparam logic [PHASE_W-1:0] PH_STOP        = 4'd10;

   // command modes
   localparam logic [MODE_W-1:0] MODE_SHORT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HALF  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LONG  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

   // item kinds
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   // register indexes
   localparam logic [2:0] REG_SHORT_ON  = 3'd0;
   localparam logic [2:0] REG_SHORT_OFF = 3'd1;
   localparam logic [2:0] REG_HALF_ON   = 3'd2;
   localparam logic [2:0] REG_HALF_OFF  = 3'd3;
   localparam logic [2:0] REG_LONG_ON   = 3'd4;
   localparam logic [2:0] REG_LONG_OFF  = 3'd5;

   localparam logic [TICK_W-1:0] SHORT_ON_RST  = 16'd100;
   localparam logic [TICK_W-1:0] SHORT_OFF_RST = 16'd100;
   localparam logic [TICK_W-1:0] HALF_ON_RST   = 16'd300;
   localparam logic [TICK_W-1:0] HALF_OFF_RST  = 16'd300;
   localparam logic [TICK_W-1:0] LONG_ON_RST   = 16'd1000;
   localparam logic [TICK_W-1:0] LONG_OFF_RST  = 16'd500;

   typedef struct packed {
      logic [TICK_W-1:0] short_on_ticks;
      logic [TICK_W-1:0] short_off_ticks;
      logic [TICK_W-1:0] half_on_ticks;
      logic [TICK_W-1:0] half_off_ticks;
      logic [TICK_W-1:0] long_on_ticks;
      logic [TICK_W-1:0] long_off_ticks;
   } bps_cfg_type;

   typedef struct packed {
      logic               kind;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
   } bps_item_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] beeps_left;
      logic [TICK_W-1:0]  timeout_left;
      logic               drive_level;
   } bps_state_type;

endpackage

[rtl/beep_pattern_sequencer_core.sv]
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tuser: kind; tdata: mode, count
// rsp     | out | rsp_tvalid/tready   | tdata: buzzer_drive, busy_res
// csr     | in  | APB, pready tied 1  | six 16-bit tick registers at 4*i
//
// One item per cycle sustained while rsp does not stall; a transaction goes
// first into the input register, then through the state update
// into the result register. Reset clears the sequencer state, the pipeline
// valids and the tick registers to their defaults. A stall on rsp holds the
// result register; req_tready drops only when both registers are full.
module beep_pattern_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] mode, [9:2] count, rest zero
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] buzzer_drive, [1] busy_res, rest zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bps_pkg::bps_cfg_type   cfg;
   bps_pkg::bps_item_type  item_ff, item_in;
   bps_pkg::bps_state_type state_ff, state_nxt;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_drive_ff, out_drive_in;
   logic                   out_busy_ff, out_busy_in;
   logic                   req_take;
   logic                   advance;

   bps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bps_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_nxt)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.kind  = req_tuser[0];
         item_in.mode  = req_tdata[1:0];
         item_in.count = req_tdata[9:2];
      end
   end

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);
   assign out_drive_in = advance ? state_nxt.drive_level : out_drive_ff;
   assign out_busy_in  = advance ? (state_nxt.phase != bps_pkg::PH_IDLE) : out_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.phase        <= bps_pkg::PH_IDLE;
         state_ff.beeps_left   <= 8'd0;
         state_ff.timeout_left <= 16'd0;
         state_ff.drive_level  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      out_drive_ff <= out_drive_in;
      out_busy_ff  <= out_busy_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_busy_ff, out_drive_ff};

endmodule

[rtl/bps_csr.sv]
module bps_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output bps_pkg::bps_cfg_type  cfg
);

   bps_pkg::bps_cfg_type cfg_ff, cfg_in;
   logic                 wr_en;
   logic [2:0]           reg_idx;
   logic [15:0]          rd_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            bps_pkg::REG_SHORT_ON:  cfg_in.short_on_ticks  = csr_pwdata[15:0];
            bps_pkg::REG_SHORT_OFF: cfg_in.short_off_ticks = csr_pwdata[15:0];
            bps_pkg::REG_HALF_ON:   cfg_in.half_on_ticks   = csr_pwdata[15:0];
            bps_pkg::REG_HALF_OFF:  cfg_in.half_off_ticks  = csr_pwdata[15:0];
            bps_pkg::REG_LONG_ON:   cfg_in.long_on_ticks   = csr_pwdata[15:0];
            bps_pkg::REG_LONG_OFF:  cfg_in.long_off_ticks  = csr_pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_on_ticks  <= bps_pkg::SHORT_ON_RST;
         cfg_ff.short_off_ticks <= bps_pkg::SHORT_OFF_RST;
         cfg_ff.half_on_ticks   <= bps_pkg::HALF_ON_RST;
         cfg_ff.half_off_ticks  <= bps_pkg::HALF_OFF_RST;
         cfg_ff.long_on_ticks   <= bps_pkg::LONG_ON_RST;
         cfg_ff.long_off_ticks  <= bps_pkg::LONG_OFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         bps_pkg::REG_SHORT_ON:  rd_val = cfg_ff.short_on_ticks;
         bps_pkg::REG_SHORT_OFF: rd_val = cfg_ff.short_off_ticks;
         bps_pkg::REG_HALF_ON:   rd_val = cfg_ff.half_on_ticks;
         bps_pkg::REG_HALF_OFF:  rd_val = cfg_ff.half_off_ticks;
         bps_pkg::REG_LONG_ON:   rd_val = cfg_ff.long_on_ticks;
         bps_pkg::REG_LONG_OFF:  rd_val = cfg_ff.long_off_ticks;
         default:                rd_val = 16'd0;
      endcase
   end

   assign csr_prdata = {16'd0, rd_val};
   assign cfg        = cfg_ff;

endmodule

[rtl/bps_step.sv]
module bps_step (
   input  bps_pkg::bps_item_type  item,
   input  bps_pkg::bps_state_type cur,
   input  bps_pkg::bps_cfg_type   cfg,
   output bps_pkg::bps_state_type nxt
);

   logic [15:0] tmo_dec;
   logic [15:0] on_ticks;
   logic [15:0] off_ticks;

   assign tmo_dec = (cur.timeout_left != 16'd0) ? cur.timeout_left - 16'd1
                                                : cur.timeout_left;

   // on/off times of the pattern the current phase belongs to
   always_comb begin
      case (cur.phase)
         bps_pkg::PH_SHORT_START, bps_pkg::PH_SHORT_ON, bps_pkg::PH_SHORT_OFF: begin
            on_ticks  = cfg.short_on_ticks;
            off_ticks = cfg.short_off_ticks;
         end
         bps_pkg::PH_HALF_START, bps_pkg::PH_HALF_ON, bps_pkg::PH_HALF_OFF: begin
            on_ticks  = cfg.half_on_ticks;
            off_ticks = cfg.half_off_ticks;
         end
         default: begin
            on_ticks  = cfg.long_on_ticks;
            off_ticks = cfg.long_off_ticks;
         end
      endcase
   end

   always_comb begin
      nxt = cur;
      if (item.kind == bps_pkg::KIND_COMMAND) begin
         // a command sets the pattern only; level and timeout stay
         nxt.beeps_left = item.count;
         case (item.mode)
            bps_pkg::MODE_SHORT: nxt.phase = bps_pkg::PH_SHORT_START;
            bps_pkg::MODE_HALF:  nxt.phase = bps_pkg::PH_HALF_START;
            bps_pkg::MODE_LONG:  nxt.phase = bps_pkg::PH_LONG_START;
            default:             nxt.phase = bps_pkg::PH_STOP;
         endcase
      end else begin
         nxt.timeout_left = tmo_dec;
         case (cur.phase)
            bps_pkg::PH_IDLE: begin
               nxt.phase = bps_pkg::PH_IDLE;
            end
            bps_pkg::PH_SHORT_START, bps_pkg::PH_HALF_START,
            bps_pkg::PH_LONG_START: begin
               if (cur.beeps_left != 8'd0) begin
                  nxt.drive_level  = 1'b1;
                  nxt.phase        = cur.phase + 4'd1;
                  nxt.timeout_left = on_ticks;
               end else begin
                  nxt.phase = bps_pkg::PH_STOP;
               end
            end
            bps_pkg::PH_SHORT_ON, bps_pkg::PH_HALF_ON, bps_pkg::PH_LONG_ON: begin
               if (tmo_dec == 16'd0) begin
                  nxt.drive_level  = 1'b0;
                  nxt.phase        = cur.phase + 4'd1;
                  nxt.timeout_left = off_ticks;
               end
            end
            bps_pkg::PH_SHORT_OFF, bps_pkg::PH_HALF_OFF, bps_pkg::PH_LONG_OFF: begin
               if (tmo_dec == 16'd0) begin
                  if (cur.beeps_left != 8'd0) begin
                     nxt.beeps_left = cur.beeps_left - 8'd1;
                  end
                  // back to the start phase of the same pattern
                  nxt.phase = cur.phase - 4'd2;
               end
            end
            default: begin
               // to-stop and unused codes: silence and go idle
               nxt.drive_level = 1'b0;
               nxt.phase       = bps_pkg::PH_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/bps_checker.sv]
`include "beep_pattern_sequencer_core_assert.svh"

module bps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_pready
);

   // a stalled result holds its payload
   `BPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // an idle sequencer never leaves the buzzer on
   `BPS_ASSERT_NOW(a_idle_silent, clock, reset, rsp_tvalid && !rsp_tdata[1], !rsp_tdata[0])

   // no result straight out of reset
   `BPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

   // register port never waits
   `BPS_ASSERT_NOW(a_pready_high, clock, reset, 1'b1, csr_pready)

endmodule

bind beep_pattern_sequencer_core bps_checker u_bps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

[dv/beep_pattern_sequencer_core_tb.sv]
module beep_pattern_sequencer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bps_pkg::*;

   // indexes past the last tick register; writes there must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned DRAIN_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct packed {
      logic busy_res;
      logic buzzer_drive;
   } buzzer_status_type;

   class buzzer_scoreboard;
      logic [TICK_W-1:0]  tick_reg [6];
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] beeps_left;
      logic [TICK_W-1:0]  timeout_left;
      logic               drive_level;
      buzzer_status_type  expected_status [$];
      int unsigned        mismatches;
      int unsigned        results_checked;
      int unsigned        ticks_seen;
      int unsigned        commands_seen [4];
      int unsigned        beeps_sounded;

      function new();
         tick_reg[REG_SHORT_ON]  = SHORT_ON_RST;
         tick_reg[REG_SHORT_OFF] = SHORT_OFF_RST;
         tick_reg[REG_HALF_ON]   = HALF_ON_RST;
         tick_reg[REG_HALF_OFF]  = HALF_OFF_RST;
         tick_reg[REG_LONG_ON]   = LONG_ON_RST;
         tick_reg[REG_LONG_OFF]  = LONG_OFF_RST;
         phase = PH_IDLE;
         beeps_left = '0;
         timeout_left = '0;
         drive_level = 1'b0;
         mismatches = 0;
         results_checked = 0;
         ticks_seen = 0;
         beeps_sounded = 0;
         foreach (commands_seen[i]) commands_seen[i] = 0;
      endfunction

      function void write_tick_reg(logic [2:0] idx, logic [TICK_W-1:0] value);
         if (idx <= REG_LONG_OFF) tick_reg[idx] = value;
      endfunction

      function void advance_tick();
         int unsigned grp;
         int unsigned stp;
         logic [PHASE_W-1:0] start;
         if (timeout_left != 0) timeout_left = timeout_left - 1'b1;
         if (phase == PH_IDLE) return;
         // codes from stop upwards all fall back to idle with the buzzer off
         if (phase >= PH_STOP) begin
            drive_level = 1'b0;
            phase = PH_IDLE;
            return;
         end
         grp = (int'(phase) - 1) / 3;
         stp = (int'(phase) - 1) % 3;
         start = PHASE_W'(1 + 3 * grp);
         case (stp)
            0: begin
               if (beeps_left != 0) begin
                  drive_level = 1'b1;
                  phase = PHASE_W'(start + 1);
                  timeout_left = tick_reg[2 * grp];
                  beeps_sounded++;
               end else begin
                  phase = PH_STOP;
               end
            end
            1: begin
               if (timeout_left == 0) begin
                  phase = PHASE_W'(start + 2);
                  drive_level = 1'b0;
                  timeout_left = tick_reg[2 * grp + 1];
               end
            end
            default: begin
               if (timeout_left == 0) begin
                  if (beeps_left != 0) beeps_left = beeps_left - 1'b1;
                  phase = start;
               end
            end
         endcase
      endfunction

      function void note_input(logic kind, logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
         buzzer_status_type status;
         if (kind == KIND_COMMAND) begin
            commands_seen[mode]++;
            case (mode)
               MODE_SHORT: phase = PH_SHORT_START;
               MODE_HALF:  phase = PH_HALF_START;
               MODE_LONG:  phase = PH_LONG_START;
               default:    phase = PH_STOP;
            endcase
            beeps_left = count;
         end else begin
            ticks_seen++;
            advance_tick();
         end
         status.buzzer_drive = drive_level;
         status.busy_res = (phase != PH_IDLE);
         expected_status.push_back(status);
      endfunction

      function void check_result(logic [7:0] tdata);
         buzzer_status_type want;
         results_checked++;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result tdata=%02h", $realtime, tdata);
            return;
         end
         want = expected_status.pop_front();
         if (tdata[0] !== want.buzzer_drive || tdata[1] !== want.busy_res) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result %0d: drive exp %0b got %0b, busy exp %0b got %0b",
                        $realtime, results_checked, want.buzzer_drive, tdata[0],
                        want.busy_res, tdata[1]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [1:0] mode, [9:2] count, rest zero
   logic [0:0]  req_tuser = '0;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] buzzer_drive, [1] busy_res, rest zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   buzzer_scoreboard sb;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned settings_used = 1;

   beep_pattern_sequencer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // sample both channels on the edge at which the transaction completes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_input(req_tuser[0], req_tdata[1:0], req_tdata[9:2]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   task automatic send_item(input logic kind, input logic [MODE_W-1:0] mode,
                            input logic [COUNT_W-1:0] count);
      // idle cycle by cycle so the idle share matches the percentage
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, count, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick();
      // mode and count mean nothing on a tick, so let them wander
      send_item(KIND_TICK, MODE_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic drain_results();
      int unsigned waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [TICK_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_tick_reg(idx, value);
   endtask

   task automatic program_ticks(input logic [TICK_W-1:0] s_on, input logic [TICK_W-1:0] s_off,
                                input logic [TICK_W-1:0] h_on, input logic [TICK_W-1:0] h_off,
                                input logic [TICK_W-1:0] l_on, input logic [TICK_W-1:0] l_off);
      drain_results();
      csr_write(REG_SHORT_ON, s_on);
      csr_write(REG_SHORT_OFF, s_off);
      csr_write(REG_HALF_ON, h_on);
      csr_write(REG_HALF_OFF, h_off);
      csr_write(REG_LONG_ON, l_on);
      csr_write(REG_LONG_OFF, l_off);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic program_random(input int unsigned hi);
      program_ticks(TICK_W'($urandom_range(0, hi)), TICK_W'($urandom_range(0, hi)),
                    TICK_W'($urandom_range(0, hi)), TICK_W'($urandom_range(0, hi)),
                    TICK_W'($urandom_range(0, hi)), TICK_W'($urandom_range(0, hi)));
   endtask

   // mostly a command followed by a run of ticks, with stray stops and bursts between
   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned run_len;
      int unsigned r;
      logic [MODE_W-1:0] mode;
      logic [COUNT_W-1:0] count;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 78) begin
            mode = ($urandom_range(99) < 90) ? MODE_W'($urandom_range(0, 2)) : MODE_STOP;
            count = ($urandom_range(99) < 75) ? COUNT_W'($urandom_range(0, 4))
                                              : COUNT_W'($urandom);
            send_item(KIND_COMMAND, mode, count);
            run_len = $urandom_range(1, 40);
            repeat (run_len) send_tick();
            sent += run_len + 1;
         end else if (r < 88) begin
            send_item(KIND_COMMAND, MODE_STOP, COUNT_W'($urandom));
            sent++;
         end else if (r < 94) begin
            send_item(KIND_COMMAND, MODE_W'($urandom), COUNT_W'($urandom));
            sent++;
         end else begin
            run_len = $urandom_range(1, 6);
            repeat (run_len) send_tick();
            sent += run_len;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 14;
      recv_stall_pct = 48;

      // reset tick lengths: start a short beep, stop it part way through
      send_item(KIND_COMMAND, MODE_SHORT, 8'd1);
      send_tick();
      send_tick();
      send_item(KIND_COMMAND, MODE_STOP, 8'd0);
      send_tick();
      send_tick();

      program_ticks(16'd1, 16'd0, 16'd0, 16'd2, 16'd2, 16'd1);
      drain_results();
      csr_write(REG_SPARE_LO, 16'hFFFF);
      csr_write(REG_SPARE_HI, 16'h0000);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);

      // zero count: start goes to stop, then idle
      send_item(KIND_COMMAND, MODE_LONG, 8'd0);
      send_item(KIND_TICK, MODE_STOP, 8'hFF);
      send_item(KIND_TICK, MODE_SHORT, 8'h00);
      // full count on half beeps with a zero on time
      send_item(KIND_COMMAND, MODE_HALF, 8'hFF);
      repeat (4) send_tick();
      // command mid-pattern leaves the level alone until the next tick
      send_item(KIND_COMMAND, MODE_SHORT, 8'd2);
      repeat (5) send_tick();
      send_item(KIND_COMMAND, MODE_LONG, 8'd1);
      repeat (3) send_tick();
      send_item(KIND_COMMAND, MODE_STOP, 8'hAA);
      send_tick();
      send_tick();

      program_random(4);
      run_random(230);
      program_ticks('0, '0, '0, '0, '0, '0);
      run_random(140);

      send_idle_pct = 48;
      recv_stall_pct = 14;
      program_ticks('1, '1, '1, '1, '1, '1);
      run_random(110);
      program_ticks(16'd0, 16'd1, TICK_W'($urandom), 16'hFFFE,
                    TICK_W'($urandom), TICK_W'($urandom_range(0, 3)));
      run_random(140);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      program_random(6);
      run_random(150);
      drain_results();
      run_random(150);
      program_ticks(TICK_W'($urandom_range(1, 3)), TICK_W'($urandom_range(1, 3)),
                    TICK_W'($urandom_range(1, 3)), TICK_W'($urandom_range(1, 3)),
                    TICK_W'($urandom_range(1, 3)), TICK_W'($urandom_range(1, 3)));
      run_random(130);

      drain_results();

      $display("%0d ticks, %0d/%0d/%0d/%0d short/half/long/stop commands, %0d tick settings",
               sb.ticks_seen, sb.commands_seen[MODE_SHORT], sb.commands_seen[MODE_HALF],
               sb.commands_seen[MODE_LONG], sb.commands_seen[MODE_STOP], settings_used);
      $display("%0d beeps sounded, %0d results checked, %0d mismatches, %0d results missing",
               sb.beeps_sounded, sb.results_checked, sb.mismatches, sb.expected_status.size());
      if (sb.mismatches == 0 && sb.expected_status.size() == 0) begin
         $display("beep_pattern_sequencer_core_tb: PASS");
      end else begin
         $display("beep_pattern_sequencer_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timed out waiting on the block");
      $display("beep_pattern_sequencer_core_tb: FAIL");
      $finish;
   end

endmodule
